// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file mfdt_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/mfdt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfdt_pkg
// Field widths and beat layouts of the mesh face de-duplication table.
// ----------------------------------------------------------------------------
package mfdt_pkg;

   localparam int ELEM_W     = 20;
   localparam int COUNT_W    = 3;
   localparam int ID_W       = 16;
   localparam int LANES      = 4;
   localparam int FACE_OUT_W = 17;
   localparam int TOTAL_W    = 18;

   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 80;

   typedef logic [REQ_DATA_W-1:0] req_data_type;
   typedef logic [RSP_DATA_W-1:0] rsp_data_type;

   // Response beat bit positions.
   localparam int RSP_NEW_BIT = 17;
   localparam int RSP_OVF_BIT = 74;

endpackage

// ===== design/mesh_face_dedup_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_face_dedup_table
// Node-to-face map that merges the faces shared by two mesh elements.
// ----------------------------------------------------------------------------
// Usage: each req beat carries one element face (element index, node count
// and four node ids). The block looks for a face already listed at every node
// of the face; if found, the element becomes its second neighbour unless
// that slot is already filled, otherwise a new face id is allocated and
// appended to each node's face list. Exactly one rsp beat comes back per req
// beat, in order, with the face id, a new-face flag, the neighbour element,
// running totals and an overflow flag. Steps: the node ids are reduced,
// the list lengths are read, then each face listed at the first node is a
// candidate that is searched for in the other nodes' lists; a match then
// reads and updates the face record, an allocation appends the new face id
// to each node's list, and the response is loaded last.
// Everything goes through the single read port of each memory.
// One item is searched at a time; req_tready is high only while idle, so a
// new beat can be taken from the cycle after the previous response is loaded.
// Reset: after reset is released the list-length memory is cleared, one
// entry per cycle over all NODES entries; no req beat is taken meanwhile.
// Stall: a finished response waits in the output register until rsp_tready;
// the next item may already be searched but is not finished before that.
// ----------------------------------------------------------------------------
module mesh_face_dedup_table
   import mfdt_pkg::*;
#(
   parameter int NODES          = 65536,
   parameter int FACES_PER_NODE = 16,
   parameter int MAX_FACES      = 131072,
   parameter int NODES_PER_FACE = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // element_index[19:0], node_count[22:20], node_a[38:23], node_b[54:39],
   // node_c[70:55], node_d[86:71], zero pad [87]
   input  req_data_type req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // face_id[16:0], face_is_new[17], neighbour_element[37:18],
   // faces_total[55:38], inner_faces[73:56], overflow[74], zero pad [79:75]
   output rsp_data_type rsp_tdata
);

   localparam int NODE_W = (NODES > 2) ? $clog2(NODES) : 1;
   localparam int LEN_W  = $clog2(FACES_PER_NODE + 1);
   localparam int SLOT_W = (FACES_PER_NODE > 1) ? $clog2(FACES_PER_NODE) : 1;
   localparam int FACE_W = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
   localparam int CNT_W  = $clog2(MAX_FACES + 1);
   localparam int LIM    = (NODES_PER_FACE < LANES) ? NODES_PER_FACE : LANES;
   // Reciprocal of NODES scaled by 2^32; exact for every 16-bit node id.
   localparam logic [31:0] RECIP = (NODES >= 65536) ? 32'd0 :
                                   32'((64'd1 << 32) / NODES + 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_RED    = 4'd1;
   localparam logic [3:0] S_LENRD  = 4'd2;
   localparam logic [3:0] S_LENWT  = 4'd3;
   localparam logic [3:0] S_SCANRD = 4'd4;
   localparam logic [3:0] S_SCANWT = 4'd5;
   localparam logic [3:0] S_CMPRD  = 4'd6;
   localparam logic [3:0] S_CMPWT  = 4'd7;
   localparam logic [3:0] S_FACERD = 4'd8;
   localparam logic [3:0] S_FACEWT = 4'd9;
   localparam logic [3:0] S_ALLOC  = 4'd10;
   localparam logic [3:0] S_APPRD  = 4'd11;
   localparam logic [3:0] S_APPWT  = 4'd12;
   localparam logic [3:0] S_DONE   = 4'd13;

   // Memories: per-node list lengths, per-node face lists, per-face record
   // holding the first element and a flag for a filled second slot.
   logic [LEN_W-1:0]  len_mem  [NODES];
   logic [FACE_W-1:0] list_mem [NODES][FACES_PER_NODE];
   logic [ELEM_W:0]   face_mem [MAX_FACES];

   logic [3:0]        state_ff, state_in;
   logic              clr_busy_ff;
   logic [NODE_W-1:0] clr_addr_ff;

   logic [ELEM_W-1:0] elem_ff;
   logic [2:0]        cnt_ff;
   logic [ID_W-1:0]   raw_ff  [LANES];
   logic [ID_W-1:0]   quo_ff  [LANES];
   logic [NODE_W-1:0] node_ff [LANES];
   logic [LEN_W-1:0]  len_q_ff [LANES];
   logic              step_ff;
   logic [1:0]        idx_ff;
   logic [LEN_W-1:0]  k_ff, j_ff;
   logic [FACE_W-1:0] cand_ff;

   logic [CNT_W-1:0]  faces_ff, inner_ff;
   logic [FACE_W-1:0] res_face_ff;
   logic              res_new_ff, res_ovf_ff;
   logic [ELEM_W-1:0] res_neigh_ff;

   logic              rsp_valid_ff;
   rsp_data_type      rsp_data_ff;

   logic [LEN_W-1:0]  len_rd_ff;
   logic [FACE_W-1:0] list_rd_ff;
   logic [ELEM_W:0]   face_rd_ff;

   logic [NODE_W-1:0] len_raddr, len_waddr, list_rnode, cur_node;
   logic [SLOT_W-1:0] list_rslot;
   logic              len_we, list_we, face_we;
   logic [LEN_W-1:0]  len_wdata;
   logic [FACE_W-1:0] face_addr;
   logic [ELEM_W:0]   face_wdata;
   logic [2:0]        cnt_raw, cnt_clamp;
   logic [1:0]        last_idx;
   logic              req_fire, out_free;

   assign req_tready = (state_ff == S_IDLE) && !clr_busy_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign cur_node   = node_ff[idx_ff];
   assign last_idx   = 2'(cnt_ff - 3'd1);

   // Node count below one counts as one, above the lane limit is clamped.
   assign cnt_raw = req_tdata[22:20];
   always_comb begin
      if (cnt_raw == 3'd0) begin
         cnt_clamp = 3'd1;
      end else if (cnt_raw > 3'(LIM)) begin
         cnt_clamp = 3'(LIM);
      end else begin
         cnt_clamp = cnt_raw;
      end
   end

   // Memory address and write-enable selection.
   always_comb begin
      len_raddr  = cur_node;
      list_rnode = node_ff[0];
      list_rslot = k_ff[SLOT_W-1:0];
      face_addr  = cand_ff;
      face_wdata = {elem_ff, 1'b0};
      face_we    = 1'b0;
      list_we    = 1'b0;
      len_we     = 1'b0;
      len_waddr  = cur_node;
      len_wdata  = LEN_W'(len_rd_ff + 1'b1);
      if (state_ff == S_CMPRD) begin
         list_rnode = cur_node;
         list_rslot = j_ff[SLOT_W-1:0];
      end
      if (clr_busy_ff) begin
         len_we    = 1'b1;
         len_waddr = clr_addr_ff;
         len_wdata = '0;
      end else if (state_ff == S_APPWT && len_rd_ff < LEN_W'(FACES_PER_NODE)) begin
         len_we  = 1'b1;
         list_we = 1'b1;
      end
      if (state_ff == S_FACEWT && !face_rd_ff[0]) begin
         face_we    = 1'b1;
         face_wdata = {face_rd_ff[ELEM_W:1], 1'b1};
      end else if (state_ff == S_ALLOC && faces_ff < CNT_W'(MAX_FACES)) begin
         face_we   = 1'b1;
         face_addr = faces_ff[FACE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      len_rd_ff <= len_mem[len_raddr];
      if (len_we) begin
         len_mem[len_waddr] <= len_wdata;
      end
   end

   always_ff @(posedge clock) begin
      list_rd_ff <= list_mem[list_rnode][list_rslot];
      if (list_we) begin
         list_mem[cur_node][len_rd_ff[SLOT_W-1:0]] <= faces_ff[FACE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      face_rd_ff <= face_mem[face_addr];
      if (face_we) begin
         face_mem[face_addr] <= face_wdata;
      end
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_fire) state_in = S_RED;
         S_RED:    if (step_ff) state_in = S_LENRD;
         S_LENRD:  state_in = S_LENWT;
         S_LENWT:  state_in = (idx_ff == last_idx) ? S_SCANRD : S_LENRD;
         S_SCANRD: state_in = (k_ff >= len_q_ff[0]) ? S_ALLOC : S_SCANWT;
         S_SCANWT: state_in = (cnt_ff == 3'd1) ? S_FACERD : S_CMPRD;
         S_CMPRD:  state_in = (j_ff >= len_q_ff[idx_ff]) ? S_SCANRD : S_CMPWT;
         S_CMPWT: begin
            if (list_rd_ff == cand_ff && idx_ff == last_idx) begin
               state_in = S_FACERD;
            end else begin
               state_in = S_CMPRD;
            end
         end
         S_FACERD: state_in = S_FACEWT;
         S_FACEWT: state_in = S_DONE;
         S_ALLOC:  state_in = (faces_ff < CNT_W'(MAX_FACES)) ? S_APPRD : S_DONE;
         S_APPRD:  state_in = S_APPWT;
         S_APPWT:  state_in = (idx_ff == last_idx) ? S_DONE : S_APPRD;
         S_DONE:   if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         faces_ff     <= '0;
         inner_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (clr_busy_ff) begin
            clr_addr_ff <= NODE_W'(clr_addr_ff + 1'b1);
            if (clr_addr_ff == NODE_W'(NODES - 1)) begin
               clr_busy_ff <= 1'b0;
            end
         end
         if (state_ff == S_FACEWT && !face_rd_ff[0]) begin
            inner_ff <= CNT_W'(inner_ff + 1'b1);
         end
         if (state_ff == S_APPWT && idx_ff == last_idx) begin
            faces_ff <= CNT_W'(faces_ff + 1'b1);
         end
         if (state_ff == S_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      logic [47:0] prod;
      logic [47:0] rem;
      unique case (state_ff)
         S_IDLE: begin
            elem_ff   <= req_tdata[19:0];
            cnt_ff    <= cnt_clamp;
            raw_ff[0] <= req_tdata[38:23];
            raw_ff[1] <= req_tdata[54:39];
            raw_ff[2] <= req_tdata[70:55];
            raw_ff[3] <= req_tdata[86:71];
            for (int l = 0; l < LANES; l++) node_ff[l] <= '0;
            step_ff     <= 1'b0;
            idx_ff      <= '0;
            res_ovf_ff  <= 1'b0;
            res_new_ff  <= 1'b0;
            res_face_ff <= '0;
         end
         S_RED: begin
            // Node ids are reduced modulo NODES by a reciprocal multiplication:
            // the first step forms the quotient, the next the remainder.
            for (int l = 0; l < LANES; l++) begin
               prod = 48'(raw_ff[l]) * 48'(RECIP);
               rem  = 48'(raw_ff[l]) - 48'(quo_ff[l]) * 48'(NODES);
               if (!step_ff) begin
                  quo_ff[l] <= prod[47:32];
               end else begin
                  node_ff[l] <= NODE_W'(rem);
               end
            end
            step_ff <= ~step_ff;
         end
         S_LENWT: begin
            len_q_ff[idx_ff] <= len_rd_ff;
            idx_ff <= 2'(idx_ff + 1'b1);
            k_ff   <= '0;
         end
         S_SCANWT: begin
            cand_ff <= list_rd_ff;
            idx_ff  <= 2'd1;
            j_ff    <= '0;
         end
         S_CMPRD: begin
            if (j_ff >= len_q_ff[idx_ff]) begin
               k_ff <= LEN_W'(k_ff + 1'b1);
            end
         end
         S_CMPWT: begin
            if (list_rd_ff == cand_ff) begin
               idx_ff <= 2'(idx_ff + 1'b1);
               j_ff   <= '0;
            end else begin
               j_ff <= LEN_W'(j_ff + 1'b1);
            end
         end
         S_FACEWT: begin
            res_face_ff  <= cand_ff;
            res_neigh_ff <= face_rd_ff[ELEM_W:1];
            res_ovf_ff   <= face_rd_ff[0];
         end
         S_ALLOC: begin
            res_neigh_ff <= elem_ff;
            idx_ff       <= '0;
            if (faces_ff < CNT_W'(MAX_FACES)) begin
               res_face_ff <= faces_ff[FACE_W-1:0];
               res_new_ff  <= 1'b1;
            end else begin
               res_ovf_ff <= 1'b1;
            end
         end
         S_APPWT: begin
            if (len_rd_ff >= LEN_W'(FACES_PER_NODE)) begin
               res_ovf_ff <= 1'b1;
            end
            idx_ff <= 2'(idx_ff + 1'b1);
         end
         default: begin
         end
      endcase
   end

   // Output register, loaded once the previous beat has been taken.
   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && out_free) begin
         rsp_data_ff <= {5'b0, res_ovf_ff, TOTAL_W'(inner_ff), TOTAL_W'(faces_ff),
                         res_neigh_ff, res_new_ff, FACE_OUT_W'(res_face_ff)};
      end
   end

endmodule

// ===== design/mfdt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfdt_checker
// Port-level checks of the mesh face de-duplication table.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mfdt_checker
   import mfdt_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input req_data_type req_tdata,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input rsp_data_type rsp_tdata
);

   `ASSERT_CLK(rsp_hold_a, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "rsp dropped")
   `ASSERT_CLK(rsp_data_a, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata), "rsp changed")
   `ASSERT_CLK(busy_a, clock, reset, req_tvalid && req_tready |=> !req_tready, "second req taken")
   `ASSERT_CLK_ALWAYS(rst_a, clock, reset |=> !rsp_tvalid && !req_tready, "activity after reset")

endmodule

bind mesh_face_dedup_table mfdt_checker u_mfdt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the mesh face de-duplication table.
// ----------------------------------------------------------------------------
// A directed table covers the first faces after reset, matches, a third match
// on a face whose neighbour slot is taken, clamped node counts, repeated
// nodes and a node list that runs full. Random faces follow, nearly half of
// them re-offered faces of earlier elements, so matches are common. Each rsp
// beat is checked against its typed row or a behavioral copy of the table.
// ----------------------------------------------------------------------------
module tb
   import mfdt_pkg::*;
();

   localparam int  LIST_DEPTH  = 16;
   localparam int  FACE_LIMIT  = 131072;
   localparam int  CYCLE_LIMIT = 10000000;
   localparam int  RANDOM_ITEMS = 1300;

   typedef struct {
      logic [ELEM_W-1:0]  elem;
      logic [COUNT_W-1:0] cnt;
      logic [ID_W-1:0]    a, b, c, d;
   } face_req_type;

   typedef struct {
      logic [FACE_OUT_W-1:0] face_id;
      logic                  is_new;
      logic [ELEM_W-1:0]     neighbour;
      logic [TOTAL_W-1:0]    total;
      logic [TOTAL_W-1:0]    inner;
      logic                  ovf;
   } face_res_type;

   // One directed row; the typed result is used only when typed is set.
   typedef struct {
      face_req_type req;
      bit           typed;
      face_res_type res;
   } dir_row_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   req_data_type req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   rsp_data_type rsp_tdata;

   // Behavioral copy of the face table.
   int unsigned node_faces[int unsigned][$];
   int unsigned face_owner[int unsigned];
   bit          face_paired[int unsigned];
   int unsigned faces_made;
   int unsigned inner_made;

   face_res_type face_expect_q[$];
   face_req_type open_faces[$];
   dir_row_type  dir_rows[$];
   int          mismatches;
   int          tx_idle;
   int          rx_idle;
   bit          stall_go;
   longint      cycles;

   mesh_face_dedup_table u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic bit list_holds(int unsigned n, int unsigned f);
      if (!node_faces.exists(n))
         return 0;
      for (int k = 0; k < node_faces[n].size(); k++)
         if (node_faces[n][k] == f)
            return 1;
      return 0;
   endfunction

   // Looks the face up in the table copy, updates it, and returns the beat
   // the block should answer with.
   function automatic face_res_type lookup_face(face_req_type q);
      face_res_type o;
      int unsigned nd[4];
      int unsigned cnt;
      int unsigned f;
      bit          hit;
      bit          all;
      cnt = q.cnt;
      if (cnt < 1) cnt = 1;
      if (cnt > 4) cnt = 4;
      nd = '{q.a, q.b, q.c, q.d};
      o.face_id = '0;
      o.is_new = 1'b0;
      o.neighbour = q.elem;
      o.ovf = 1'b0;
      hit = 0;
      if (node_faces.exists(nd[0])) begin
         for (int k = 0; k < node_faces[nd[0]].size() && !hit; k++) begin
            f = node_faces[nd[0]][k];
            all = 1;
            for (int i = 1; i < cnt; i++)
               if (!list_holds(nd[i], f)) all = 0;
            if (all) begin
               hit = 1;
               o.face_id = FACE_OUT_W'(f);
               o.neighbour = ELEM_W'(face_owner[f]);
               if (face_paired[f]) begin
                  o.ovf = 1'b1;
               end else begin
                  face_paired[f] = 1;
                  inner_made++;
               end
            end
         end
      end
      if (!hit) begin
         if (faces_made >= FACE_LIMIT) begin
            o.ovf = 1'b1;
         end else begin
            f = faces_made;
            // A repeated node id is appended once per occurrence.
            for (int i = 0; i < cnt; i++) begin
               if (!node_faces.exists(nd[i]))
                  node_faces[nd[i]] = {};
               if (node_faces[nd[i]].size() >= LIST_DEPTH)
                  o.ovf = 1'b1;
               else
                  node_faces[nd[i]].insert(node_faces[nd[i]].size(), f);
            end
            face_owner[f] = q.elem;
            face_paired[f] = 0;
            faces_made++;
            o.face_id = FACE_OUT_W'(f);
            o.is_new = 1'b1;
         end
      end
      o.total = TOTAL_W'(faces_made);
      o.inner = TOTAL_W'(inner_made);
      return o;
   endfunction

   function automatic face_req_type make_req(int unsigned elem, int unsigned cnt,
                                             int unsigned a, int unsigned b,
                                             int unsigned c, int unsigned d);
      face_req_type q;
      q.elem = ELEM_W'(elem);
      q.cnt = COUNT_W'(cnt);
      q.a = ID_W'(a);
      q.b = ID_W'(b);
      q.c = ID_W'(c);
      q.d = ID_W'(d);
      return q;
   endfunction

   function automatic face_res_type make_res(int unsigned id, bit is_new,
                                             int unsigned nb, int unsigned tot,
                                             int unsigned inn, bit ovf);
      face_res_type r;
      r.face_id = FACE_OUT_W'(id);
      r.is_new = is_new;
      r.neighbour = ELEM_W'(nb);
      r.total = TOTAL_W'(tot);
      r.inner = TOTAL_W'(inn);
      r.ovf = ovf;
      return r;
   endfunction

   function automatic void add_row(face_req_type q, bit typed, face_res_type r);
      dir_row_type row;
      row.req = q;
      row.typed = typed;
      row.res = r;
      dir_rows.insert(dir_rows.size(), row);
   endfunction

   // Offers one face beat with a random lead-in gap and waits for it to be
   // taken. The expectation is queued at the accepting edge.
   task automatic send_face(face_req_type q, bit typed, face_res_type r);
      face_res_type want;
      while ($urandom_range(0, 99) < tx_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, q.d, q.c, q.b, q.a, q.cnt, q.elem};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      want = lookup_face(q);
      face_expect_q.insert(face_expect_q.size(), typed ? r : want);
   endtask

   // Random face. Nearly half the beats re-offer an open face of another element with
   // its nodes rotated, so the search has to find it from a different node.
   task automatic send_random_face();
      face_req_type q;
      face_req_type p;
      int unsigned pick;
      int unsigned eff;
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 45 && open_faces.size() > 0) begin
         pick = $urandom_range(0, open_faces.size() - 1);
         p = open_faces[pick];
         // A few re-offers keep the face open, so a third element hits a
         // neighbour slot that is already taken.
         if (roll < 40)
            open_faces.delete(pick);
         eff = (p.cnt < 1) ? 1 : (p.cnt > 4) ? 4 : p.cnt;
         q = p;
         q.elem = ELEM_W'($urandom_range(0, 20'hFFFFF));
         if (eff == 2) begin
            q.a = p.b; q.b = p.a;
         end else if (eff == 3) begin
            q.a = p.b; q.b = p.c; q.c = p.a;
         end else if (eff == 4) begin
            q.a = p.d; q.b = p.a; q.c = p.b; q.d = p.c;
         end
      end else begin
         q.elem = ELEM_W'($urandom_range(0, 20'hFFFFF));
         if ($urandom_range(0, 9) < 8)
            q.cnt = COUNT_W'($urandom_range(1, 4));
         else
            q.cnt = COUNT_W'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 7));
         if ($urandom_range(0, 9) == 0) begin
            // A crowded corner of the mesh: long lists, some of them full.
            q.a = ID_W'($urandom_range(0, 63));
            q.b = ID_W'($urandom_range(0, 63));
            q.c = ID_W'($urandom_range(0, 63));
            q.d = ID_W'($urandom_range(0, 63));
         end else begin
            q.a = ID_W'($urandom_range(0, 16'hFFFF));
            q.b = ID_W'($urandom_range(0, 16'hFFFF));
            q.c = ID_W'($urandom_range(0, 16'hFFFF));
            q.d = ID_W'($urandom_range(0, 16'hFFFF));
         end
         if (open_faces.size() < 200)
            open_faces.insert(open_faces.size(), q);
      end
      send_face(q, 1'b0, make_res(0, 0, 0, 0, 0, 0));
   endtask

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
   endtask

   // Response monitor: every accepted beat is checked against the oldest
   // expectation.
   always @(posedge clock) begin
      face_res_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (face_expect_q.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected response beat, expected none, actual 0x%0h",
                     $time, rsp_tdata);
         end else begin
            want = face_expect_q.pop_front();
            check_field("face_id", want.face_id, rsp_tdata[16:0]);
            check_field("face_is_new", want.is_new, rsp_tdata[RSP_NEW_BIT]);
            check_field("neighbour_element", want.neighbour, rsp_tdata[37:18]);
            check_field("faces_total", want.total, rsp_tdata[55:38]);
            check_field("inner_faces", want.inner, rsp_tdata[73:56]);
            check_field("overflow", want.ovf, rsp_tdata[RSP_OVF_BIT]);
         end
      end
   end

   // Receiver: random ready, plus one long hold-off on request so the block
   // fills and stalls its input.
   initial begin
      forever begin
         @(posedge clock);
         if (stall_go) begin
            stall_go = 0;
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(0, 99) >= rx_idle);
      end
   end

   // Watchdog; the limit covers the list-length clearing pass after reset.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      mismatches = 0;
      faces_made = 0;
      inner_made = 0;
      cycles = 0;
      stall_go = 0;
      tx_idle = 35;
      rx_idle = 49;

      // First face after reset, then two more elements offer it.
      add_row(make_req(0, 3, 1, 2, 3, 0), 1, make_res(0, 1, 0, 1, 0, 0));
      add_row(make_req(20'hFFFFF, 3, 3, 1, 2, 16'hFFFF), 1, make_res(0, 0, 0, 1, 1, 0));
      add_row(make_req(5, 3, 2, 3, 1, 7), 1, make_res(0, 0, 0, 1, 1, 1));
      // A zero node count is a one-node face.
      add_row(make_req(7, 0, 16'hFFFF, 0, 0, 0), 1, make_res(1, 1, 7, 2, 1, 0));
      add_row(make_req(8, 0, 16'hFFFF, 9, 9, 9), 1, make_res(1, 0, 7, 2, 2, 0));
      // Counts above four are clamped.
      add_row(make_req(9, 7, 10, 11, 12, 13), 0, make_res(0, 0, 0, 0, 0, 0));
      add_row(make_req(20'hAAAAA, 5, 13, 12, 11, 10), 0, make_res(0, 0, 0, 0, 0, 0));
      // Repeated node ids.
      add_row(make_req(20'h55555, 4, 20, 20, 20, 21), 0, make_res(0, 0, 0, 0, 0, 0));
      add_row(make_req(11, 2, 20, 20, 0, 0), 0, make_res(0, 0, 0, 0, 0, 0));
      // Node 100 collects faces until its list is full.
      for (int k = 0; k < 17; k++)
         add_row(make_req(100 + k, 2, 100, 200 + k, 0, 0), 0, make_res(0, 0, 0, 0, 0, 0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_face(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 3) begin
            tx_idle = 49;
            rx_idle = 35;
         end else if (i == 2 * RANDOM_ITEMS / 3) begin
            tx_idle = 0;
            rx_idle = 0;
            stall_go = 1;
         end
         send_random_face();
      end
      req_tvalid <= 1'b0;

      while (face_expect_q.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);

      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/mfdt_pkg.sv
design/mesh_face_dedup_table.sv
design/mfdt_checker.sv
sim/tb.sv
